[rtl/dtg_pkg.sv]
// Shared definitions for the DTMF dual-tone generator: field widths, codes,
// fixed-point constants and the key-to-frequency lookup.
// Depends on nothing; every other file of the block imports it.
package dtg_pkg;

   // Field widths of the request, response and control channels.
   localparam int ACTION_W   = 2;
   localparam int KEY_W      = 8;
   localparam int FREQ_W     = 15;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Register widths.
   localparam int PHASE_STEP_W  = 23;
   localparam int TONE_LENGTH_W = 24;
   localparam int CHANNELS_W    = 2;

   // Sine magnitude width (amplitude 16383 fits in 14 bits).
   localparam int MAG_W = 14;

   // Request action codes.
   localparam logic [ACTION_W-1:0] ACTION_KEY  = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_FREQ = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_TICK = 2'd2;

   // Control register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TONE_LENGTH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_16    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNELS    = 2'd3;

   // Register reset values.
   localparam logic [PHASE_STEP_W-1:0]  PHASE_STEP_RESET  = 23'd536871;
   localparam logic [TONE_LENGTH_W-1:0] TONE_LENGTH_RESET = 24'd8000;
   localparam logic [CHANNELS_W-1:0]    CHANNELS_RESET    = 2'd1;

   // Fixed-point constants for building the quarter-wave sine table.
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] AMPLITUDE   = 64'd16383;

   // Sign flip that turns a two's complement high byte into offset binary.
   localparam logic [BYTE_W-1:0] OFFSET_FLIP = 8'h80;

   // Tone frequencies in hertz.
   localparam logic [FREQ_W-1:0] FREQ_NONE  = 15'd0;
   localparam logic [FREQ_W-1:0] FREQ_350   = 15'd350;
   localparam logic [FREQ_W-1:0] FREQ_440   = 15'd440;
   localparam logic [FREQ_W-1:0] FREQ_480   = 15'd480;
   localparam logic [FREQ_W-1:0] FREQ_620   = 15'd620;
   localparam logic [FREQ_W-1:0] FREQ_ROW_1 = 15'd697;
   localparam logic [FREQ_W-1:0] FREQ_ROW_2 = 15'd770;
   localparam logic [FREQ_W-1:0] FREQ_ROW_3 = 15'd852;
   localparam logic [FREQ_W-1:0] FREQ_ROW_4 = 15'd941;
   localparam logic [FREQ_W-1:0] FREQ_COL_1 = 15'd1209;
   localparam logic [FREQ_W-1:0] FREQ_COL_2 = 15'd1336;
   localparam logic [FREQ_W-1:0] FREQ_COL_3 = 15'd1477;
   localparam logic [FREQ_W-1:0] FREQ_COL_4 = 15'd1633;

   // Result of a key lookup.
   typedef struct packed {
      logic              hit;
      logic [FREQ_W-1:0] freq_low;
      logic [FREQ_W-1:0] freq_high;
   } key_entry_type;

   // Maps an ASCII key to its frequency pair; unknown keys give no hit.
   function automatic key_entry_type key_lookup(input logic [KEY_W-1:0] key);
      key_entry_type entry;
      entry = '{hit: 1'b1, freq_low: FREQ_NONE, freq_high: FREQ_NONE};
      case (key)
         "1": begin entry.freq_low = FREQ_ROW_1; entry.freq_high = FREQ_COL_1; end
         "2": begin entry.freq_low = FREQ_ROW_1; entry.freq_high = FREQ_COL_2; end
         "3": begin entry.freq_low = FREQ_ROW_1; entry.freq_high = FREQ_COL_3; end
         "A": begin entry.freq_low = FREQ_ROW_1; entry.freq_high = FREQ_COL_4; end
         "4": begin entry.freq_low = FREQ_ROW_2; entry.freq_high = FREQ_COL_1; end
         "5": begin entry.freq_low = FREQ_ROW_2; entry.freq_high = FREQ_COL_2; end
         "6": begin entry.freq_low = FREQ_ROW_2; entry.freq_high = FREQ_COL_3; end
         "B": begin entry.freq_low = FREQ_ROW_2; entry.freq_high = FREQ_COL_4; end
         "7": begin entry.freq_low = FREQ_ROW_3; entry.freq_high = FREQ_COL_1; end
         "8": begin entry.freq_low = FREQ_ROW_3; entry.freq_high = FREQ_COL_2; end
         "9": begin entry.freq_low = FREQ_ROW_3; entry.freq_high = FREQ_COL_3; end
         "C": begin entry.freq_low = FREQ_ROW_3; entry.freq_high = FREQ_COL_4; end
         "*": begin entry.freq_low = FREQ_ROW_4; entry.freq_high = FREQ_COL_1; end
         "0": begin entry.freq_low = FREQ_ROW_4; entry.freq_high = FREQ_COL_2; end
         "#": begin entry.freq_low = FREQ_ROW_4; entry.freq_high = FREQ_COL_3; end
         "D": begin entry.freq_low = FREQ_ROW_4; entry.freq_high = FREQ_COL_4; end
         "R": begin entry.freq_low = FREQ_440;   entry.freq_high = FREQ_480;   end
         "S": begin entry.freq_low = FREQ_480;   entry.freq_high = FREQ_620;   end
         "T": begin entry.freq_low = FREQ_350;   entry.freq_high = FREQ_440;   end
         ",": begin entry.freq_low = FREQ_NONE;  entry.freq_high = FREQ_NONE;  end
         default: begin
            entry.hit = 1'b0;
         end
      endcase
      return entry;
   endfunction

endpackage

[rtl/dtg_if.sv]
// Channel interfaces of the DTMF dual-tone generator: request, response and
// control write channels, each with valid and ready. Depends on dtg_pkg.
interface dtg_req_if import dtg_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [KEY_W-1:0]    key_code;
   logic [FREQ_W-1:0]   freq_low_hz;
   logic [FREQ_W-1:0]   freq_high_hz;

   modport source (output valid, action, key_code, freq_low_hz, freq_high_hz,
                   input ready);
   modport sink   (input valid, action, key_code, freq_low_hz, freq_high_hz,
                   output ready);
endinterface

interface dtg_rsp_if import dtg_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] sample_byte;
   logic              last_byte;

   modport source (output valid, sample_byte, last_byte, input ready);
   modport sink   (input valid, sample_byte, last_byte, output ready);
endinterface

interface dtg_csr_if import dtg_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/dtmf_dual_tone_generator.sv]
// Top level of the DTMF dual-tone generator: command decode, two phase
// accumulators, quarter-wave sine table and the output byte serialiser.
// Depends on dtg_pkg and the channel interfaces in dtg_if.sv.
//
// A request is taken while the table read stage is empty or passes its sample on.
// Key commands with a known key and frequency commands load both phase steps,
// clear both phases and load the tone length at once; they give no response. A
// sample tick while a tone is active reads the two sine magnitudes from the
// registered quarter-wave table, forms the sample in the following cycle and
// hands one to four bytes (8 or 16 bits, one or two channels) to the response
// channel, one byte per cycle while the receiver is ready, from the byte buffer
// register that follows the table read register. The serialiser sets the tick
// rate; a new tick is taken while the previous one is still being sent. The sine
// table holds 2^(SINE_INDEX_BITS-2)+1 entries, built at elaboration, two read ports.
module dtmf_dual_tone_generator
   import dtg_pkg::*;
#(
   parameter int PHASE_BITS      = 32,
   parameter int SINE_INDEX_BITS = 12,
   parameter int LENGTH_BITS     = 24
) (
   input logic       clock,
   input logic       reset,
   dtg_req_if.sink   req_if,
   dtg_rsp_if.source rsp_if,
   dtg_csr_if.sink   csr_if
);

   localparam int QUARTER   = 2 ** (SINE_INDEX_BITS - 2);
   localparam int Q_W       = SINE_INDEX_BITS - 1;
   localparam int PROD_W    = FREQ_W + PHASE_STEP_W;
   localparam int SHIFT     = 32 - PHASE_BITS;
   localparam int SAMPLE_W  = MAG_W + 3;

   typedef logic [MAG_W-1:0] rom_type [QUARTER + 1];

   // Quarter-wave table: odd polynomial to x^11 in Q30, rounded half up.
   function automatic rom_type build_rom();
      rom_type     rom;
      logic [63:0] t;
      logic [63:0] t2;
      logic [63:0] acc;
      logic [63:0] s;
      for (int q = 0; q <= QUARTER; q++) begin
         t   = (64'(q) * Q30_HALF_PI) >> (SINE_INDEX_BITS - 2);
         t2  = (t * t) >> 30;
         acc = Q30_ONE;
         acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd110;
         acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd72;
         acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd42;
         acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd20;
         acc = Q30_ONE - ((t2 * acc) >> 30) / 64'd6;
         s   = (t * acc) >> 30;
         rom[q] = MAG_W'((s * AMPLITUDE + (Q30_ONE >> 1)) >> 30);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   // Sine table address and sign taken from one phase.
   typedef struct packed {
      logic [Q_W-1:0] q;
      logic           neg;
   } rom_addr_type;

   function automatic rom_addr_type rom_addr(input logic [PHASE_BITS-1:0] phase);
      logic [SINE_INDEX_BITS-1:0] idx;
      logic [Q_W-1:0]             r;
      rom_addr_type               addr;
      idx = phase[PHASE_BITS-1 -: SINE_INDEX_BITS];
      r   = {1'b0, idx[SINE_INDEX_BITS-3:0]};
      addr.q   = idx[SINE_INDEX_BITS-2] ? (Q_W'(QUARTER) - r) : r;
      addr.neg = idx[SINE_INDEX_BITS-1];
      return addr;
   endfunction

   // Control registers.
   logic [PHASE_STEP_W-1:0]  phase_step_ff,  phase_step_in;
   logic [TONE_LENGTH_W-1:0] tone_length_ff, tone_length_in;
   logic                     width16_ff,     width16_in;
   logic [CHANNELS_W-1:0]    channels_ff,    channels_in;

   // Tone state.
   logic [PHASE_BITS-1:0]  phase_first_ff,  phase_first_in;
   logic [PHASE_BITS-1:0]  phase_second_ff, phase_second_in;
   logic [PHASE_BITS-1:0]  step_first_ff,   step_first_in;
   logic [PHASE_BITS-1:0]  step_second_ff,  step_second_in;
   logic [LENGTH_BITS-1:0] remaining_ff,    remaining_in;

   // Table read stage.
   logic             rom_valid_ff, rom_valid_in;
   logic [MAG_W-1:0] mag_first_ff, mag_second_ff;
   logic             neg_first_ff, neg_first_in;
   logic             neg_second_ff, neg_second_in;
   logic             wide_ff, wide_in;
   logic             dual_ff, dual_in;

   // Byte serialiser.
   logic              buf_valid_ff, buf_valid_in;
   logic [BYTE_W-1:0] bytes_ff [4];
   logic [BYTE_W-1:0] bytes_in [4];
   logic [1:0]        cursor_ff, cursor_in;
   logic [1:0]        last_ff,   last_in;

   logic                         req_fire;
   logic                         rsp_fire;
   logic                         csr_fire;
   logic                         start;
   logic                         tick;
   logic                         buf_done;
   logic                         buf_free;
   logic                         rom_advance;
   key_entry_type                key_entry;
   logic [FREQ_W-1:0]            freq_low;
   logic [FREQ_W-1:0]            freq_high;
   logic [PROD_W-1:0]            prod_low;
   logic [PROD_W-1:0]            prod_high;
   logic [LENGTH_BITS+TONE_LENGTH_W-1:0] length_ext;
   rom_addr_type                 addr_first;
   rom_addr_type                 addr_second;
   logic signed [SAMPLE_W-1:0]   term_first;
   logic signed [SAMPLE_W-1:0]   term_second;
   logic signed [SAMPLE_W-1:0]   sample;
   logic [BYTE_W-1:0]            byte_low;
   logic [BYTE_W-1:0]            byte_high;

   // Handshakes.
   assign rom_advance  = rom_valid_ff && buf_free;
   assign req_if.ready = !rom_valid_ff || rom_advance;
   assign csr_if.ready = 1'b1;
   assign req_fire     = req_if.valid && req_if.ready;
   assign rsp_fire     = rsp_if.valid && rsp_if.ready;
   assign csr_fire     = csr_if.valid && csr_if.ready;
   assign buf_done     = rsp_fire && (cursor_ff == last_ff);
   assign buf_free     = !buf_valid_ff || buf_done;

   // Command decode and phase step products.
   assign key_entry  = key_lookup(req_if.key_code);
   assign start      = req_fire && ((req_if.action == ACTION_KEY && key_entry.hit) ||
                                    req_if.action == ACTION_FREQ);
   assign tick       = req_fire && req_if.action == ACTION_TICK &&
                       remaining_ff != '0;
   assign freq_low   = (req_if.action == ACTION_KEY) ? key_entry.freq_low
                                                     : req_if.freq_low_hz;
   assign freq_high  = (req_if.action == ACTION_KEY) ? key_entry.freq_high
                                                     : req_if.freq_high_hz;
   assign prod_low   = PROD_W'(freq_low)  * PROD_W'(phase_step_ff);
   assign prod_high  = PROD_W'(freq_high) * PROD_W'(phase_step_ff);
   assign length_ext = {{LENGTH_BITS{1'b0}}, tone_length_ff};

   assign addr_first  = rom_addr(phase_first_ff);
   assign addr_second = rom_addr(phase_second_ff);

   // Control register writes.
   always_comb begin
      phase_step_in  = phase_step_ff;
      tone_length_in = tone_length_ff;
      width16_in     = width16_ff;
      channels_in    = channels_ff;
      if (csr_fire) begin
         case (csr_if.index)
            CSR_PHASE_STEP:  phase_step_in  = csr_if.data[PHASE_STEP_W-1:0];
            CSR_TONE_LENGTH: tone_length_in = csr_if.data[TONE_LENGTH_W-1:0];
            CSR_WIDTH_16:    width16_in     = csr_if.data[0];
            CSR_CHANNELS:    channels_in    = csr_if.data[CHANNELS_W-1:0];
            default: begin
               phase_step_in = phase_step_ff;
            end
         endcase
      end
   end

   // Tone state: a command restarts the tone, a tick advances both phases.
   always_comb begin
      phase_first_in  = phase_first_ff;
      phase_second_in = phase_second_ff;
      step_first_in   = step_first_ff;
      step_second_in  = step_second_ff;
      remaining_in    = remaining_ff;
      if (start) begin
         step_first_in   = prod_low[SHIFT +: PHASE_BITS];
         step_second_in  = prod_high[SHIFT +: PHASE_BITS];
         phase_first_in  = '0;
         phase_second_in = '0;
         remaining_in    = length_ext[LENGTH_BITS-1:0];
      end else if (tick) begin
         phase_first_in  = phase_first_ff + step_first_ff;
         phase_second_in = phase_second_ff + step_second_ff;
         remaining_in    = remaining_ff - LENGTH_BITS'(1);
      end
   end

   // Table read stage control and payload.
   always_comb begin
      rom_valid_in  = rom_valid_ff;
      neg_first_in  = neg_first_ff;
      neg_second_in = neg_second_ff;
      wide_in       = wide_ff;
      dual_in       = dual_ff;
      if (tick) begin
         rom_valid_in  = 1'b1;
         neg_first_in  = addr_first.neg;
         neg_second_in = addr_second.neg;
         wide_in       = width16_ff;
         dual_in       = channels_ff[1];
      end else if (rom_advance) begin
         rom_valid_in  = 1'b0;
      end
   end

   // Sample sum and its byte forms.
   always_comb begin
      term_first  = SAMPLE_W'($signed({3'b000, mag_first_ff}));
      term_second = SAMPLE_W'($signed({3'b000, mag_second_ff}));
      if (neg_first_ff) begin
         term_first = -term_first;
      end
      if (neg_second_ff) begin
         term_second = -term_second;
      end
      sample    = term_first + term_second;
      byte_low  = sample[7:0];
      byte_high = sample[15:8];
   end

   // Byte serialiser: load a whole sample, then send one byte per transaction.
   always_comb begin
      buf_valid_in = buf_valid_ff;
      cursor_in    = cursor_ff;
      last_in      = last_ff;
      for (int i = 0; i < 4; i++) begin
         bytes_in[i] = bytes_ff[i];
      end
      if (rom_advance) begin
         buf_valid_in = 1'b1;
         cursor_in    = 2'd0;
         if (wide_ff) begin
            bytes_in[0] = byte_low;
            bytes_in[1] = byte_high;
            bytes_in[2] = byte_low;
            bytes_in[3] = byte_high;
            last_in     = dual_ff ? 2'd3 : 2'd1;
         end else begin
            bytes_in[0] = byte_high ^ OFFSET_FLIP;
            bytes_in[1] = byte_high ^ OFFSET_FLIP;
            bytes_in[2] = byte_high ^ OFFSET_FLIP;
            bytes_in[3] = byte_high ^ OFFSET_FLIP;
            last_in     = dual_ff ? 2'd1 : 2'd0;
         end
      end else if (buf_done) begin
         buf_valid_in = 1'b0;
      end else if (rsp_fire) begin
         cursor_in    = cursor_ff + 2'd1;
      end
   end

   assign rsp_if.valid       = buf_valid_ff;
   assign rsp_if.sample_byte = bytes_ff[cursor_ff];
   assign rsp_if.last_byte   = (cursor_ff == last_ff);

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= PHASE_STEP_RESET;
         tone_length_ff  <= TONE_LENGTH_RESET;
         width16_ff      <= 1'b0;
         channels_ff     <= CHANNELS_RESET;
         phase_first_ff  <= '0;
         phase_second_ff <= '0;
         step_first_ff   <= '0;
         step_second_ff  <= '0;
         remaining_ff    <= '0;
         rom_valid_ff    <= 1'b0;
         buf_valid_ff    <= 1'b0;
         cursor_ff       <= 2'd0;
         last_ff         <= 2'd0;
      end else begin
         phase_step_ff   <= phase_step_in;
         tone_length_ff  <= tone_length_in;
         width16_ff      <= width16_in;
         channels_ff     <= channels_in;
         phase_first_ff  <= phase_first_in;
         phase_second_ff <= phase_second_in;
         step_first_ff   <= step_first_in;
         step_second_ff  <= step_second_in;
         remaining_ff    <= remaining_in;
         rom_valid_ff    <= rom_valid_in;
         buf_valid_ff    <= buf_valid_in;
         cursor_ff       <= cursor_in;
         last_ff         <= last_in;
      end
   end

   // Payload registers, including the two registered sine table reads.
   always_ff @(posedge clock) begin
      if (tick) begin
         mag_first_ff  <= SINE_ROM[addr_first.q];
         mag_second_ff <= SINE_ROM[addr_second.q];
      end
      neg_first_ff  <= neg_first_in;
      neg_second_ff <= neg_second_in;
      wide_ff       <= wide_in;
      dual_ff       <= dual_in;
      for (int i = 0; i < 4; i++) begin
         bytes_ff[i] <= bytes_in[i];
      end
   end

endmodule

[tb/sv/dtmf_dual_tone_generator_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the DTMF dual-tone generator: a directed table, then
// randomised tone commands and sample ticks under several register settings.
// Depends on dtg_pkg, the channel interfaces in dtg_if.sv and the RTL top level.
module dtmf_dual_tone_generator_tb;
   import dtg_pkg::*;

   localparam int CLOCK_HALF     = 2;
   localparam int RESET_CYCLES   = 7;
   localparam int WAIT_MAX       = 16;
   localparam int HOLD_CYCLES    = 250;
   localparam int HOLD_SPACING   = 600;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int REPORT_LIMIT   = 10;
   localparam int ZERO_OFFSET    = 32768;
   localparam int QUARTER_BITS   = 10;
   localparam logic [10:0] QUARTER = 11'd1024;

   // Action code with no meaning to the block.
   localparam logic [ACTION_W-1:0] ACTION_IDLE = 2'd3;
   // Byte for a zero sample in 8-bit offset binary.
   localparam logic [BYTE_W-1:0] MIDSCALE = 8'h80;
   localparam int DIAL_KEY_COUNT = 20;
   localparam logic [8*DIAL_KEY_COUNT-1:0] DIAL_KEYS = "1234567890*#ABCDRST,";

   typedef struct packed {
      logic [BYTE_W-1:0] sample_byte;
      logic              last_byte;
   } audio_byte_t;

   // How the expected bytes of a directed row are obtained.
   typedef enum logic [1:0] {
      OUTCOME_PREDICTED,
      OUTCOME_SILENT,
      OUTCOME_MIDSCALE
   } outcome_t;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key_code;
      logic [FREQ_W-1:0]   freq_low_hz;
      logic [FREQ_W-1:0]   freq_high_hz;
      outcome_t            outcome;
   } stimulus_row_t;

   typedef struct packed {
      logic [PHASE_STEP_W-1:0]  step_per_hz;
      logic [TONE_LENGTH_W-1:0] tone_length;
      logic                     wide;
      logic [CHANNELS_W-1:0]    channels;
   } tone_setup_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dtg_req_if req_bus ();
   dtg_rsp_if rsp_bus ();
   dtg_csr_if csr_bus ();

   dtmf_dual_tone_generator DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // Register copies and tone state of the predictor.
   logic [PHASE_STEP_W-1:0]  cfg_step_per_hz = PHASE_STEP_RESET;
   logic [TONE_LENGTH_W-1:0] cfg_tone_length = TONE_LENGTH_RESET;
   logic                     cfg_wide        = 1'b0;
   logic [CHANNELS_W-1:0]    cfg_channels    = CHANNELS_RESET;
   logic [31:0]              phase_low  = '0;
   logic [31:0]              phase_high = '0;
   logic [31:0]              incr_low   = '0;
   logic [31:0]              incr_high  = '0;
   logic [TONE_LENGTH_W-1:0] ticks_left = '0;

   audio_byte_t expected_bytes[$];
   int fault_count    = 0;
   int bytes_seen     = 0;
   int cycle_count    = 0;
   int sender_quiet   = 0;
   int receiver_quiet = 0;

   // Directed rows: the first tick after any command that starts a tone reads both
   // sines at phase zero, so in the reset format it gives the mid-scale byte.
   stimulus_row_t directed_rows [24] = '{
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h7FFF, OUTCOME_SILENT},
      '{ACTION_IDLE, 8'hFF, 15'h7FFF, 15'h0000, OUTCOME_SILENT},
      '{ACTION_KEY,  8'hFF, 15'h7FFF, 15'h7FFF, OUTCOME_SILENT},
      '{ACTION_TICK, 8'hFF, 15'h7FFF, 15'h7FFF, OUTCOME_SILENT},
      '{ACTION_KEY,  "1",   15'h0000, 15'h0000, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_TICK, 8'hFF, 15'h7FFF, 15'h7FFF, OUTCOME_PREDICTED},
      '{ACTION_KEY,  "D",   15'h7FFF, 15'h7FFF, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_KEY,  ",",   15'h0000, 15'h0000, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_FREQ, 8'h00, 15'h7FFF, 15'h7FFF, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_FREQ, 8'hFF, 15'd1000,  15'h0000, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_MIDSCALE},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_KEY,  8'h00, 15'h0000, 15'h0000, OUTCOME_SILENT},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED},
      '{ACTION_TICK, 8'h00, 15'h0000, 15'h0000, OUTCOME_PREDICTED}
   };

   // Register settings for the random phases; a last phase draws its own.
   tone_setup_t fixed_setups [5] = '{
      '{PHASE_STEP_RESET, TONE_LENGTH_RESET, 1'b1, 2'd2},
      '{23'd65537,        24'd3,             1'b0, 2'd2},
      '{23'd4294967,      24'hFFFFFF,        1'b1, 2'd3},
      '{23'd100000,       24'd0,             1'b0, 2'd0},
      '{23'd300000,       24'd1,             1'b1, 2'd1}
   };
   int phase_items [6] = '{60, 50, 60, 12, 40, 40};

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // Splits a key into its row and column frequencies; unknown keys miss.
   function automatic bit dial_pair(input logic [KEY_W-1:0] key,
                                    output logic [FREQ_W-1:0] lo_hz,
                                    output logic [FREQ_W-1:0] hi_hz);
      bit hit;
      hit   = 1'b1;
      lo_hz = FREQ_NONE;
      hi_hz = FREQ_NONE;
      case (key)
         "1", "2", "3", "A": lo_hz = FREQ_ROW_1;
         "4", "5", "6", "B": lo_hz = FREQ_ROW_2;
         "7", "8", "9", "C": lo_hz = FREQ_ROW_3;
         "*", "0", "#", "D": lo_hz = FREQ_ROW_4;
         "R":                lo_hz = FREQ_440;
         "S":                lo_hz = FREQ_480;
         "T":                lo_hz = FREQ_350;
         ",":                lo_hz = FREQ_NONE;
         default:            hit = 1'b0;
      endcase
      case (key)
         "1", "4", "7", "*": hi_hz = FREQ_COL_1;
         "2", "5", "8", "0": hi_hz = FREQ_COL_2;
         "3", "6", "9", "#": hi_hz = FREQ_COL_3;
         "A", "B", "C", "D": hi_hz = FREQ_COL_4;
         "R":                hi_hz = FREQ_480;
         "S":                hi_hz = FREQ_620;
         "T":                hi_hz = FREQ_440;
         default:            hi_hz = FREQ_NONE;
      endcase
      return hit;
   endfunction

   // Quarter-wave magnitude: odd Taylor series to x^11 in Q30, nested from
   // the top term down, then scaled to the amplitude with rounding.
   function automatic logic [MAG_W-1:0] sine_magnitude(input logic [10:0] q);
      bit [63:0] angle;
      bit [63:0] angle_sq;
      bit [63:0] series;
      bit [63:0] unit_sine;
      angle    = (64'(q) * Q30_HALF_PI) >> QUARTER_BITS;
      angle_sq = (angle * angle) >> 30;
      series   = Q30_ONE;
      series   = Q30_ONE - ((angle_sq * series) >> 30) / 110;
      series   = Q30_ONE - ((angle_sq * series) >> 30) / 72;
      series   = Q30_ONE - ((angle_sq * series) >> 30) / 42;
      series   = Q30_ONE - ((angle_sq * series) >> 30) / 20;
      series   = Q30_ONE - ((angle_sq * series) >> 30) / 6;
      unit_sine = (angle * series) >> 30;
      return MAG_W'((unit_sine * AMPLITUDE + (Q30_ONE >> 1)) >> 30);
   endfunction

   // Signed sine from the top twelve phase bits, folded into one quarter.
   function automatic int signed_sine(input logic [31:0] phase);
      logic [11:0] slot;
      logic [10:0] q;
      int          mag;
      slot = phase[31:20];
      q    = slot[10] ? QUARTER - 11'(slot[9:0]) : 11'(slot[9:0]);
      mag  = int'(sine_magnitude(q));
      return slot[11] ? -mag : mag;
   endfunction

   function automatic logic [31:0] tone_step(input logic [FREQ_W-1:0] freq);
      logic [37:0] product;
      product = 38'(freq) * 38'(cfg_step_per_hz);
      return product[31:0];
   endfunction

   // Zero for a quiet stretch, otherwise a random wait.
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, WAIT_MAX);
   endfunction

   task automatic report_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   // Predicts one accepted transaction; the bytes are queued when record is set.
   task automatic advance_tone(input logic [ACTION_W-1:0] action,
                               input logic [KEY_W-1:0] key,
                               input logic [FREQ_W-1:0] lo_hz,
                               input logic [FREQ_W-1:0] hi_hz,
                               input bit record);
      logic [FREQ_W-1:0] f_lo;
      logic [FREQ_W-1:0] f_hi;
      bit                load;
      int                sum;
      logic [31:0]       word;
      int                lanes;
      int                lane;
      load = 1'b0;
      f_lo = lo_hz;
      f_hi = hi_hz;
      if (action == ACTION_KEY) begin
         load = dial_pair(key, f_lo, f_hi);
      end else if (action == ACTION_FREQ) begin
         load = 1'b1;
      end else if (action == ACTION_TICK && ticks_left != '0) begin
         sum   = signed_sine(phase_low) + signed_sine(phase_high);
         word  = 32'(sum + ZERO_OFFSET);
         lanes = (cfg_channels <= 2'd1) ? 1 : 2;
         if (record) begin
            for (lane = 0; lane < lanes; lane++) begin
               if (cfg_wide) begin
                  expected_bytes.push_back({word[7:0], 1'b0});
                  expected_bytes.push_back({word[15:8] ^ OFFSET_FLIP, lane == lanes - 1});
               end else begin
                  expected_bytes.push_back({word[15:8], lane == lanes - 1});
               end
            end
         end
         phase_low  = phase_low + incr_low;
         phase_high = phase_high + incr_high;
         ticks_left = ticks_left - 1'b1;
      end
      // A new tone restarts both phases at once.
      if (load) begin
         incr_low   = tone_step(f_lo);
         incr_high  = tone_step(f_hi);
         phase_low  = '0;
         phase_high = '0;
         ticks_left = cfg_tone_length;
      end
   endtask

   // Offers one request transaction after a random gap; starts and ends at a
   // falling edge.
   task automatic send_item(input logic [ACTION_W-1:0] action,
                            input logic [KEY_W-1:0] key,
                            input logic [FREQ_W-1:0] lo_hz,
                            input logic [FREQ_W-1:0] hi_hz,
                            input outcome_t outcome);
      int gap;
      gap = draw_wait(sender_quiet);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.action       <= action;
      req_bus.key_code     <= key;
      req_bus.freq_low_hz  <= lo_hz;
      req_bus.freq_high_hz <= hi_hz;
      req_bus.valid        <= 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      advance_tone(action, key, lo_hz, hi_hz, outcome == OUTCOME_PREDICTED);
      if (outcome == OUTCOME_MIDSCALE) begin
         expected_bytes.push_back({MIDSCALE, 1'b1});
      end
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_bus.index <= reg_index;
      csr_bus.data  <= data;
      csr_bus.valid <= 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (reg_index)
         CSR_PHASE_STEP:  cfg_step_per_hz = data[PHASE_STEP_W-1:0];
         CSR_TONE_LENGTH: cfg_tone_length = data[TONE_LENGTH_W-1:0];
         CSR_WIDTH_16:    cfg_wide        = data[0];
         CSR_CHANNELS:    cfg_channels    = data[CHANNELS_W-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Unused upper data bits are filled at random; the block must drop them.
   task automatic apply_setup(input tone_setup_t setup);
      write_register(CSR_PHASE_STEP, {1'($urandom), setup.step_per_hz});
      write_register(CSR_TONE_LENGTH, setup.tone_length);
      write_register(CSR_WIDTH_16, {23'($urandom), setup.wide});
      write_register(CSR_CHANNELS, {22'($urandom), setup.channels});
      csr_bus.valid <= 1'b0;
   endtask

   // Waits for every expected byte, then lets a command in flight finish.
   task automatic settle();
      while (expected_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Stimulus: reset, directed table, then random phases under new settings.
   initial begin
      logic [ACTION_W-1:0] action;
      logic [KEY_W-1:0]    key;
      logic [FREQ_W-1:0]   lo_hz;
      logic [FREQ_W-1:0]   hi_hz;
      logic [FREQ_W-1:0]   spare_lo;
      logic [FREQ_W-1:0]   spare_hi;
      tone_setup_t         setup;
      int                  counted;
      int                  roll;
      int                  drain;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACTION_KEY;
      req_bus.key_code     = '0;
      req_bus.freq_low_hz  = '0;
      req_bus.freq_high_hz = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.index        = CSR_PHASE_STEP;
      csr_bus.data         = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].action, directed_rows[i].key_code,
                   directed_rows[i].freq_low_hz, directed_rows[i].freq_high_hz,
                   directed_rows[i].outcome);
      end
      req_bus.valid <= 1'b0;

      for (int p = 0; p < 6; p++) begin
         settle();
         if (p < 5) begin
            setup = fixed_setups[p];
         end else begin
            setup.step_per_hz = 23'($urandom_range(65537, 4294967));
            setup.tone_length = 24'($urandom_range(1, 50));
            setup.wide        = 1'($urandom);
            setup.channels    = 2'($urandom);
         end
         apply_setup(setup);
         counted = 0;
         // Mostly commands followed by runs of ticks, with some noise.
         while (counted < phase_items[p]) begin
            roll   = $urandom_range(0, 99);
            action = ACTION_TICK;
            key    = 8'($urandom);
            lo_hz  = 15'($urandom);
            hi_hz  = 15'($urandom);
            if (roll >= 94) begin
               action = ACTION_IDLE;
            end else if (roll >= 88) begin
               action = ACTION_KEY;
            end else if (roll >= 78) begin
               action = ACTION_FREQ;
               if ($urandom_range(0, 3) == 0) hi_hz = FREQ_NONE;
            end else if (roll >= 66) begin
               action = ACTION_KEY;
               key    = DIAL_KEYS[8*$urandom_range(0, DIAL_KEY_COUNT-1) +: 8];
            end
            send_item(action, key, lo_hz, hi_hz, OUTCOME_PREDICTED);
            if (action != ACTION_IDLE &&
                !(action == ACTION_KEY && !dial_pair(key, spare_lo, spare_hi))) begin
               counted++;
            end
         end
         req_bus.valid <= 1'b0;
      end

      drain = 0;
      while (expected_bytes.size() != 0 && drain < DRAIN_LIMIT) begin
         @(negedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (expected_bytes.size() != 0) begin
         report_fault($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
      end
      if (fault_count == 0) begin
         $display("dtmf_dual_tone_generator_tb: done, clean");
      end else begin
         $display("dtmf_dual_tone_generator_tb: done, errors");
      end
      $finish;
   end

   // Receiver: random stalls, and now and then a long hold-off that lets the
   // block fill up and push back on requests.
   initial begin
      int wait_cycles;
      int next_hold_at;
      next_hold_at = 40;
      rsp_bus.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (bytes_seen >= next_hold_at) begin
            wait_cycles  = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
         end else begin
            wait_cycles = draw_wait(receiver_quiet);
         end
         if (wait_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Compares each response transaction with the oldest expected byte.
   always @(posedge clock) begin : check_bytes
      audio_byte_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         bytes_seen++;
         if (expected_bytes.size() == 0) begin
            report_fault($sformatf("unexpected byte %02h last %0b",
                                   rsp_bus.sample_byte, rsp_bus.last_byte));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_bus.sample_byte !== want.sample_byte ||
                rsp_bus.last_byte !== want.last_byte) begin
               report_fault($sformatf("byte %0d: expected %02h last %0b, got %02h last %0b",
                                      bytes_seen, want.sample_byte, want.last_byte,
                                      rsp_bus.sample_byte, rsp_bus.last_byte));
            end
         end
      end
   end

   // Overall cycle limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("dtmf_dual_tone_generator_tb: done, errors");
         $finish;
      end
   end

endmodule
